/* rtl/sector_cache_directory_fifo_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sector cache directory
// Shared property forms: same-cycle and next-cycle implication, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_DIRECTORY_FIFO_ASSERT_SVH
`define SECTOR_CACHE_DIRECTORY_FIFO_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SCDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scdf_pkg.sv */
// ----------------------------------------------------------------------------
// scdf_pkg
// Field widths, beat layout and defaults for the sector cache directory.
// ----------------------------------------------------------------------------
package scdf_pkg;

    // sector size must be a power of two; the position split is a shift
    localparam int SECTOR_BYTES = 512;
    localparam int OFF_W        = $clog2(SECTOR_BYTES);

    localparam int POS_W        = 25;
    localparam int IDX_W        = 16;
    localparam int DISK_W       = 32;
    localparam int FSEC_W       = POS_W - OFF_W;
    localparam int SLOT_OUT_W   = 4;
    localparam int OFFSET_OUT_W = 9;

    // input beat: file_position, map_index, disk_sector; tuser = mode
    localparam int S_POS_LSB    = 0;
    localparam int S_IDX_LSB    = S_POS_LSB + POS_W;
    localparam int S_DISK_LSB   = S_IDX_LSB + IDX_W;
    localparam int S_USED_W     = S_DISK_LSB + DISK_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // output beat: slot, byte_offset, fetch_sector; tuser = {fetch_request, hit}
    localparam int M_SLOT_LSB   = 0;
    localparam int M_OFF_LSB    = M_SLOT_LSB + SLOT_OUT_W;
    localparam int M_SEC_LSB    = M_OFF_LSB + OFFSET_OUT_W;
    localparam int M_USED_W     = M_SEC_LSB + DISK_W;
    localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;
    localparam int M_TUSER_W    = 2;
    localparam int M_HIT_BIT    = 0;
    localparam int M_FETCH_BIT  = 1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam int SLOTS_DEFAULT       = 16;
    localparam int MAP_ENTRIES_DEFAULT = 65536;

endpackage

/* rtl/scdf_ram.sv */
// ----------------------------------------------------------------------------
// scdf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scdf_front.sv */
// ----------------------------------------------------------------------------
// scdf_front
// Input side: takes beats, splits read positions into sector and offset,
// and queues classified requests for the back end (two entries).
// ----------------------------------------------------------------------------
module scdf_front #(
    parameter int MAP_AW = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scdf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic                              q_valid,
    output logic                              q_is_read,
    output logic [MAP_AW-1:0]                 q_addr,
    output logic [scdf_pkg::OFFSET_OUT_W-1:0] q_offset,
    output logic [scdf_pkg::DISK_W-1:0]       q_disk,
    input  logic                              q_pop
);

    logic [scdf_pkg::POS_W-1:0]        pos;
    logic [scdf_pkg::IDX_W-1:0]        idx;
    logic [scdf_pkg::FSEC_W-1:0]       fsec;
    logic                              in_is_read;
    logic [MAP_AW-1:0]                 in_addr;
    logic [scdf_pkg::OFFSET_OUT_W-1:0] in_offset;
    logic                              push;

    logic                              is_read_reg [2];
    logic [MAP_AW-1:0]                 addr_reg    [2];
    logic [scdf_pkg::OFFSET_OUT_W-1:0] offset_reg  [2];
    logic [scdf_pkg::DISK_W-1:0]       disk_reg    [2];
    logic                              wr_ptr_reg, wr_ptr_next;
    logic                              rd_ptr_reg, rd_ptr_next;
    logic [1:0]                        count_reg, count_next;

    assign pos  = s_axis_tdata[scdf_pkg::S_POS_LSB +: scdf_pkg::POS_W];
    assign idx  = s_axis_tdata[scdf_pkg::S_IDX_LSB +: scdf_pkg::IDX_W];
    assign fsec = pos[scdf_pkg::POS_W-1:scdf_pkg::OFF_W];

    // a load is addressed by map_index, a read by its file sector; both wrap
    assign in_is_read = (s_axis_tuser == scdf_pkg::MODE_READ);
    assign in_addr    = in_is_read ? MAP_AW'(fsec) : MAP_AW'(idx);
    assign in_offset  = in_is_read ? scdf_pkg::OFFSET_OUT_W'(pos[scdf_pkg::OFF_W-1:0])
                                   : '0;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            is_read_reg[wr_ptr_reg] <= in_is_read;
            addr_reg[wr_ptr_reg]    <= in_addr;
            offset_reg[wr_ptr_reg]  <= in_offset;
            disk_reg[wr_ptr_reg]    <= s_axis_tdata[scdf_pkg::S_DISK_LSB +: scdf_pkg::DISK_W];
        end
    end

    assign q_valid   = (count_reg != 2'd0);
    assign q_is_read = is_read_reg[rd_ptr_reg];
    assign q_addr    = addr_reg[rd_ptr_reg];
    assign q_offset  = offset_reg[rd_ptr_reg];
    assign q_disk    = disk_reg[rd_ptr_reg];

endmodule

/* rtl/scdf_back.sv */
// ----------------------------------------------------------------------------
// scdf_back
// Directory engine: slot owner table with parallel match, round-robin victim,
// map RAM access and the output register.
// ----------------------------------------------------------------------------
module scdf_back #(
    parameter int SLOTS  = 16,
    parameter int MAP_AW = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  logic                              q_is_read,
    input  logic [MAP_AW-1:0]                 q_addr,
    input  logic [scdf_pkg::OFFSET_OUT_W-1:0] q_offset,
    input  logic [scdf_pkg::DISK_W-1:0]       q_disk,
    output logic                              q_pop,
    output logic                              ram_we,
    output logic [MAP_AW-1:0]                 ram_waddr,
    output logic [scdf_pkg::DISK_W-1:0]       ram_wdata,
    output logic [MAP_AW-1:0]                 ram_raddr,
    input  logic [scdf_pkg::DISK_W-1:0]       ram_rdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [scdf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic [scdf_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    localparam int SLOT_W = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_RESOLVE = 2'b10
    } state_t;

    state_t                            state_reg, state_next;
    logic [MAP_AW-1:0]                 owner_reg [SLOTS];
    logic [SLOTS-1:0]                  used_reg;
    logic [SLOTS-1:0]                  match_reg;
    logic [SLOT_W-1:0]                 victim_reg, victim_next;
    logic [MAP_AW-1:0]                 key_reg;
    logic [scdf_pkg::OFFSET_OUT_W-1:0] off_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [scdf_pkg::M_TDATA_W-1:0]    out_data_reg, out_data_next;
    logic [scdf_pkg::M_TUSER_W-1:0]    out_user_reg, out_user_next;

    logic                              out_free;
    logic                              take_read;
    logic                              hit;
    logic                              miss_update;
    logic [SLOT_W-1:0]                 hit_idx;
    logic [SLOT_W-1:0]                 res_slot;
    logic [scdf_pkg::DISK_W-1:0]       res_sector;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && out_free;
    assign take_read = q_pop && q_is_read;

    assign ram_we    = q_pop && !q_is_read;
    assign ram_waddr = q_addr;
    assign ram_wdata = q_disk;
    assign ram_raddr = q_addr;

    // owners are unique, so at most one match bit is set
    assign hit = |match_reg;
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
        end
    end

    assign miss_update = (state_reg == S_RESOLVE) && !hit;
    assign res_slot    = hit ? hit_idx : victim_reg;
    assign res_sector  = hit ? '0 : ram_rdata;
    assign victim_next = (victim_reg == SLOT_W'(SLOTS - 1)) ? '0 : victim_reg + SLOT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_is_read)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_user_next  = '0;
                    end
                end
            end
            S_RESOLVE:
            begin
                // output register was freed when this read left the queue
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_data_next[scdf_pkg::M_SLOT_LSB +: scdf_pkg::SLOT_OUT_W] =
                    scdf_pkg::SLOT_OUT_W'(res_slot);
                out_data_next[scdf_pkg::M_OFF_LSB +: scdf_pkg::OFFSET_OUT_W] = off_reg;
                out_data_next[scdf_pkg::M_SEC_LSB +: scdf_pkg::DISK_W] = res_sector;
                out_user_next[scdf_pkg::M_HIT_BIT]   = hit;
                out_user_next[scdf_pkg::M_FETCH_BIT] = !hit;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (miss_update)
            begin
                // overwriting the owner drops the old sector's residency
                used_reg[victim_reg] <= 1'b1;
                victim_reg           <= victim_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        if (take_read)
        begin
            key_reg <= q_addr;
            off_reg <= q_offset;
            for (int i = 0; i < SLOTS; i++)
            begin
                match_reg[i] <= used_reg[i] && (owner_reg[i] == q_addr);
            end
        end
        if (miss_update)
        begin
            owner_reg[victim_reg] <= key_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* rtl/sector_cache_directory_fifo.sv */
// ----------------------------------------------------------------------------
// sector_cache_directory_fifo
// Sector cache directory with round-robin slot replacement.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one entry of the sector map RAM and answers
// with an all-zero result; a read beat (tuser = 1) looks its file sector up
// in the slot owner table and answers with hit, slot and byte offset, plus a
// fetch request and the mapped disk sector on a miss. Requests pass a
// two-entry queue to the directory engine, which answers a load directly and
// resolves a read in order: the owner match and the map RAM's registered read
// first, then the slot decision and table update in S_RESOLVE. A request
// leaves the queue only when the result register is empty or its beat is
// taken in that cycle; meanwhile up to two beats wait in the queue. No
// clearing pass is needed after reset. SECTOR_BYTES and MAP_ENTRIES must be
// powers of two.
module sector_cache_directory_fifo #(
    parameter int SLOTS       = scdf_pkg::SLOTS_DEFAULT,
    parameter int MAP_ENTRIES = scdf_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // file_position[24:0], map_index[40:25], disk_sector[72:41], zero pad
    input  logic [scdf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // slot[3:0], byte_offset[12:4], fetch_sector[44:13], zero pad
    output logic [scdf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // hit[0], fetch_request[1]
    output logic [scdf_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int MAP_AW = $clog2(MAP_ENTRIES);

    logic                              q_valid;
    logic                              q_is_read;
    logic [MAP_AW-1:0]                 q_addr;
    logic [scdf_pkg::OFFSET_OUT_W-1:0] q_offset;
    logic [scdf_pkg::DISK_W-1:0]       q_disk;
    logic                              q_pop;
    logic                              ram_we;
    logic [MAP_AW-1:0]                 ram_waddr;
    logic [scdf_pkg::DISK_W-1:0]       ram_wdata;
    logic [MAP_AW-1:0]                 ram_raddr;
    logic [scdf_pkg::DISK_W-1:0]       ram_rdata;

    scdf_front #(
        .MAP_AW (MAP_AW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_is_read     (q_is_read),
        .q_addr        (q_addr),
        .q_offset      (q_offset),
        .q_disk        (q_disk),
        .q_pop         (q_pop)
    );

    scdf_ram #(
        .WIDTH (scdf_pkg::DISK_W),
        .DEPTH (MAP_ENTRIES)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scdf_back #(
        .SLOTS  (SLOTS),
        .MAP_AW (MAP_AW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_is_read     (q_is_read),
        .q_addr        (q_addr),
        .q_offset      (q_offset),
        .q_disk        (q_disk),
        .q_pop         (q_pop),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/scdf_checker.sv */
// ----------------------------------------------------------------------------
// scdf_checker
// Port-level checks for the sector cache directory, bound to the top level.
// ----------------------------------------------------------------------------
`include "sector_cache_directory_fifo_assert.svh"

module scdf_checker #(
    parameter int SLOTS = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [scdf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [scdf_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam int SLOT_LIMIT = (SLOTS > 16) ? 16 : SLOTS;

    logic                             res_hit;
    logic                             res_fetch;
    logic [scdf_pkg::SLOT_OUT_W:0]    res_slot;
    logic [scdf_pkg::DISK_W-1:0]      res_sector;

    assign res_hit    = m_axis_tuser[scdf_pkg::M_HIT_BIT];
    assign res_fetch  = m_axis_tuser[scdf_pkg::M_FETCH_BIT];
    assign res_slot   = {1'b0, m_axis_tdata[scdf_pkg::M_SLOT_LSB +: scdf_pkg::SLOT_OUT_W]};
    assign res_sector = m_axis_tdata[scdf_pkg::M_SEC_LSB +: scdf_pkg::DISK_W];

    `SCDF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")

    `SCDF_ASSERT_NOW(a_hit_xor_fetch, clk, rst_n, m_axis_tvalid,
        !(res_hit && res_fetch), "hit and fetch request both set")

    `SCDF_ASSERT_NOW(a_no_fetch_no_sector, clk, rst_n, m_axis_tvalid && !res_fetch,
        res_sector == '0, "fetch sector set without fetch request")

    `SCDF_ASSERT_NOW(a_slot_range, clk, rst_n, m_axis_tvalid,
        res_slot < (scdf_pkg::SLOT_OUT_W + 1)'(SLOT_LIMIT), "slot out of range")

endmodule

bind sector_cache_directory_fifo scdf_checker #(
    .SLOTS (SLOTS)
) u_scdf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
